/* rtl/core/gfau_pkg.sv */
// Shared types, codes and the GF(2^8) multiply function for the arithmetic unit.
package gfau_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned PolyW = 9;
  localparam int unsigned FuncW = 3;

  localparam logic [PolyW-1:0] PolyReset = 9'h11D;
  localparam logic [ByteW-1:0] InvExp    = 8'd254;
  localparam logic [ByteW-1:0] ByteOne   = 8'h01;

  typedef enum logic [FuncW-1:0] {
    FUNC_MUL = 3'd0,
    FUNC_DIV = 3'd1,
    FUNC_ADD = 3'd2,
    FUNC_SUB = 3'd3,
    FUNC_INV = 3'd4,
    FUNC_POW = 3'd5
  } func_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POWER,
    ST_DIV_MUL,
    ST_WRITE
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;     // capture operands of an accepted beat
    logic step;     // one square-and-multiply iteration
    logic div_mul;  // a * inverse(b)
    logic write;    // move result into output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic exp_zero;
    logic is_div;
    logic out_stall;  // output register full and not being drained
  } sts_t;

  // Carry-less product, then reduction from bit 15 down to bit 8.
  function automatic logic [ByteW-1:0] gf_mul(input logic [ByteW-1:0] x,
                                              input logic [ByteW-1:0] y,
                                              input logic [PolyW-1:0] poly);
    logic [2*ByteW-1:0] p;
    p = '0;
    for (int i = 0; i < ByteW; i++) begin
      if (y[i]) begin
        p = p ^ ({{ByteW{1'b0}}, x} << i);
      end
    end
    for (int b = 2*ByteW-1; b >= ByteW; b--) begin
      if (p[b]) begin
        p = p ^ ({{(2*ByteW-PolyW){1'b0}}, poly} << (b - ByteW));
      end
    end
    return p[ByteW-1:0];
  endfunction

endpackage

/* rtl/core/gfau_if.sv */
// Valid/ready channel interfaces for request and result beats.
interface gfau_req_if;
  logic                            valid;
  logic                            ready;
  logic [gfau_pkg::FuncW-1:0]      func;
  logic [gfau_pkg::ByteW-1:0]      operand_a;
  logic [gfau_pkg::ByteW-1:0]      operand_b;

  modport source (output valid, output func, output operand_a, output operand_b,
                  input ready);
  modport sink   (input valid, input func, input operand_a, input operand_b,
                  output ready);
endinterface

interface gfau_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [gfau_pkg::ByteW-1:0] result;

  modport source (output valid, output result, input ready);
  modport sink   (input valid, input result, output ready);
endinterface

/* rtl/core/gfau_ctrl.sv */
// Sequencer for the arithmetic unit: issues load, step, divide and write commands.
module gfau_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       req_valid_i,
  input  logic [gfau_pkg::FuncW-1:0] req_func_i,
  output logic                       req_ready_o,
  input  gfau_pkg::sts_t             sts_i,
  output gfau_pkg::cmd_t             cmd_o
);

  gfau_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gfau_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      gfau_pkg::ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          if (req_func_i == gfau_pkg::FUNC_DIV || req_func_i == gfau_pkg::FUNC_INV ||
              req_func_i == gfau_pkg::FUNC_POW) begin
            state_d = gfau_pkg::ST_POWER;
          end else begin
            state_d = gfau_pkg::ST_WRITE;
          end
        end
      end
      gfau_pkg::ST_POWER: begin
        if (sts_i.exp_zero) begin
          state_d = sts_i.is_div ? gfau_pkg::ST_DIV_MUL : gfau_pkg::ST_WRITE;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      gfau_pkg::ST_DIV_MUL: begin
        cmd_o.div_mul = 1'b1;
        state_d       = gfau_pkg::ST_WRITE;
      end
      gfau_pkg::ST_WRITE: begin
        if (!sts_i.out_stall) begin
          cmd_o.write = 1'b1;
          state_d     = gfau_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = gfau_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/core/gfau_dpath.sv */
// Datapath: operand, accumulator and exponent registers, two field multipliers, output register.
module gfau_dpath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [gfau_pkg::PolyW-1:0] cfg_wdata_i,
  input  logic [gfau_pkg::FuncW-1:0] req_func_i,
  input  logic [gfau_pkg::ByteW-1:0] req_operand_a_i,
  input  logic [gfau_pkg::ByteW-1:0] req_operand_b_i,
  input  gfau_pkg::cmd_t             cmd_i,
  output gfau_pkg::sts_t             sts_o,
  output logic                       rsp_valid_o,
  output logic [gfau_pkg::ByteW-1:0] rsp_result_o,
  input  logic                       rsp_ready_i
);

  logic [gfau_pkg::PolyW-1:0] poly_q;
  logic [gfau_pkg::FuncW-1:0] func_q;
  logic [gfau_pkg::ByteW-1:0] opa_q, opb_q, acc_q, base_q, exp_q;
  logic [gfau_pkg::ByteW-1:0] res_q, res_d;
  logic                       valid_q;
  logic [gfau_pkg::ByteW-1:0] mx, my, prod0, prod1;
  logic                       load_div, load_inv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q <= gfau_pkg::PolyReset;
    end else if (cfg_we_i) begin
      poly_q <= cfg_wdata_i;
    end
  end

  // multiplier 0 is shared: acc*base while stepping, a*inv at the end of a
  // divide, a*b for a plain multiply
  always_comb begin
    if (cmd_i.div_mul) begin
      mx = opa_q;
      my = acc_q;
    end else if (cmd_i.step) begin
      mx = acc_q;
      my = base_q;
    end else begin
      mx = opa_q;
      my = opb_q;
    end
  end

  assign prod0 = gfau_pkg::gf_mul(mx, my, poly_q);
  assign prod1 = gfau_pkg::gf_mul(base_q, base_q, poly_q);

  assign load_div = (req_func_i == gfau_pkg::FUNC_DIV);
  assign load_inv = (req_func_i == gfau_pkg::FUNC_INV);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= req_func_i;
      opa_q  <= req_operand_a_i;
      opb_q  <= req_operand_b_i;
      acc_q  <= gfau_pkg::ByteOne;
      base_q <= load_div ? req_operand_b_i : req_operand_a_i;
      exp_q  <= (load_div || load_inv) ? gfau_pkg::InvExp : req_operand_b_i;
    end else if (cmd_i.step) begin
      if (exp_q[0]) begin
        acc_q <= prod0;
      end
      base_q <= prod1;
      exp_q  <= exp_q >> 1;
    end else if (cmd_i.div_mul) begin
      acc_q <= prod0;
    end
  end

  always_comb begin
    case (func_q)
      gfau_pkg::FUNC_MUL: res_d = prod0;
      gfau_pkg::FUNC_DIV,
      gfau_pkg::FUNC_INV,
      gfau_pkg::FUNC_POW: res_d = acc_q;
      gfau_pkg::FUNC_ADD,
      gfau_pkg::FUNC_SUB: res_d = opa_q ^ opb_q;
      default:            res_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (cmd_i.write) begin
      valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.write) begin
      res_q <= res_d;
    end
  end

  assign sts_o.exp_zero  = (exp_q == '0);
  assign sts_o.is_div    = (func_q == gfau_pkg::FUNC_DIV);
  assign sts_o.out_stall = valid_q && !rsp_ready_i;

  assign rsp_valid_o  = valid_q;
  assign rsp_result_o = res_q;

endmodule

/* rtl/core/gf256_arithmetic_unit.sv */
// Top level of the GF(2^8) arithmetic unit: controller plus datapath.
//
//  channel | dir | handshake    | payload
//  --------+-----+--------------+-------------------------------------------
//  req_i   | in  | valid/ready  | func[2:0], operand_a[7:0], operand_b[7:0]
//  rsp_o   | out | valid/ready  | result[7:0]
//  cfg     | in  | cfg_we_i     | cfg_wdata_i[8:0] = reduction_poly
//
// Mul/add/sub and unused codes go straight to the write state; power, inverse
// and divide first run the square-and-multiply sequence, one exponent bit
// per cycle through two field multipliers (acc*base and base*base).
// Reset: async active low; clears the sequencer and the output valid, and
// loads reduction_poly with 0x11D. No clearing pass.
// Stalls: the result sits in an output register, so a new request beat is
// taken while an earlier result waits; the sequencer only holds in its
// write state when that register is still full and not being drained.
module gf256_arithmetic_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [gfau_pkg::PolyW-1:0] cfg_wdata_i,
  gfau_req_if.sink                   req_i,
  gfau_rsp_if.source                 rsp_o
);

  gfau_pkg::cmd_t cmd;
  gfau_pkg::sts_t sts;

  gfau_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_func_i  (req_i.func),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  gfau_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .req_func_i      (req_i.func),
    .req_operand_a_i (req_i.operand_a),
    .req_operand_b_i (req_i.operand_b),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .rsp_valid_o     (rsp_o.valid),
    .rsp_result_o    (rsp_o.result),
    .rsp_ready_i     (rsp_o.ready)
  );

endmodule

/* rtl/core/gfau_checker.sv */
// Port-level checker for the arithmetic unit, bound to the top level.
module gfau_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       req_valid_i,
  input logic                       req_ready_i,
  input logic [gfau_pkg::FuncW-1:0] req_func_i,
  input logic                       rsp_valid_i,
  input logic                       rsp_ready_i,
  input logic [gfau_pkg::ByteW-1:0] rsp_result_i
);

  // one beat in flight: ready drops right after an accepted beat
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while a beat is in flight");

  // a stalled result holds
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_result_i))
    else $error("result dropped or changed while stalled");

  // add/sub need no iteration: the sequencer goes straight to its write state
  a_xor_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i &&
    (req_func_i == gfau_pkg::FUNC_ADD || req_func_i == gfau_pkg::FUNC_SUB)
    |-> ##2 rsp_valid_i)
    else $error("add/sub result late");

  // ready never comes back before the previous result has been written out
  a_ready_after_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(req_ready_i) |-> rsp_valid_i)
    else $error("ready returned without a result");

endmodule

bind gf256_arithmetic_unit gfau_checker u_gfau_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .req_func_i   (req_i.func),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_result_i (rsp_o.result)
);

/* sim/tb_gf256_arithmetic_unit.sv */
// Self-checking testbench for the GF(2^8) arithmetic unit.
module tb_gf256_arithmetic_unit;
  timeunit 1ns;
  timeprecision 1ps;

  // func values outside the enum; the unit answers zero for them
  localparam logic [gfau_pkg::FuncW-1:0] FuncSpare6 = 3'd6;
  localparam logic [gfau_pkg::FuncW-1:0] FuncSpare7 = 3'd7;

  localparam int ReportLimit   = 10;
  localparam int WatchdogLimit = 5000;  // cycles with no beat on either channel
  localparam int SettleCycles  = 16;    // > slowest op (divide)

  // One request waiting for the driver. hold_for_drain makes the driver
  // keep the channel quiet until every outstanding answer is back.
  typedef struct {
    logic [gfau_pkg::FuncW-1:0] func;
    logic [gfau_pkg::ByteW-1:0] operand_a;
    logic [gfau_pkg::ByteW-1:0] operand_b;
    logic                       hold_for_drain;
  } op_t;

  // Predicted answer plus the context needed to report a miss.
  typedef struct {
    logic [gfau_pkg::FuncW-1:0] func;
    logic [gfau_pkg::ByteW-1:0] operand_a;
    logic [gfau_pkg::ByteW-1:0] operand_b;
    logic [gfau_pkg::PolyW-1:0] modulus;
    logic [gfau_pkg::ByteW-1:0] result;
  } answer_t;

  logic                       clk_i  = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       cfg_we;
  logic [gfau_pkg::PolyW-1:0] cfg_wdata;

  gfau_req_if req_if ();
  gfau_rsp_if rsp_if ();

  gf256_arithmetic_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  op_t                        ops_pending[$];
  answer_t                    answers_due[$];
  logic [gfau_pkg::PolyW-1:0] field_modulus = gfau_pkg::PolyReset;  // our copy of the register
  int                         send_gap_pct   = 0;
  int                         recv_stall_pct = 0;
  int                         mismatches     = 0;
  int                         quiet_cycles   = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------

  // Horner-style multiply: shift the running sum left by one, fold bit 8 back with
  // the modulus, then add x if the next multiplier bit is set. Gives the
  // same remainder as reducing the full 15-bit product from the top.
  function automatic logic [gfau_pkg::ByteW-1:0] field_product(
      logic [gfau_pkg::ByteW-1:0] x,
      logic [gfau_pkg::ByteW-1:0] y,
      logic [gfau_pkg::PolyW-1:0] m);
    logic [gfau_pkg::PolyW-1:0] sum;
    sum = '0;
    for (int i = gfau_pkg::ByteW - 1; i >= 0; i--) begin
      sum = {sum[gfau_pkg::ByteW-1:0], 1'b0};
      if (sum[gfau_pkg::ByteW]) begin
        sum = sum ^ m;
      end
      if (y[i]) begin
        sum[gfau_pkg::ByteW-1:0] = sum[gfau_pkg::ByteW-1:0] ^ x;
      end
    end
    return sum[gfau_pkg::ByteW-1:0];
  endfunction

  // Left-to-right exponentiation; base^0 is 1, zero base included.
  function automatic logic [gfau_pkg::ByteW-1:0] field_power(
      logic [gfau_pkg::ByteW-1:0] base,
      logic [gfau_pkg::ByteW-1:0] ex,
      logic [gfau_pkg::PolyW-1:0] m);
    logic [gfau_pkg::ByteW-1:0] acc;
    acc = gfau_pkg::ByteOne;
    for (int i = gfau_pkg::ByteW - 1; i >= 0; i--) begin
      acc = field_product(acc, acc, m);
      if (ex[i]) begin
        acc = field_product(acc, base, m);
      end
    end
    return acc;
  endfunction

  function automatic logic [gfau_pkg::ByteW-1:0] gf_answer(
      logic [gfau_pkg::FuncW-1:0] f,
      logic [gfau_pkg::ByteW-1:0] a,
      logic [gfau_pkg::ByteW-1:0] b,
      logic [gfau_pkg::PolyW-1:0] m);
    case (f)
      gfau_pkg::FUNC_MUL: return field_product(a, b, m);
      // x / 0 comes out as 0 since 0^254 = 0
      gfau_pkg::FUNC_DIV:
        return field_product(a, field_power(b, gfau_pkg::InvExp, m), m);
      gfau_pkg::FUNC_ADD, gfau_pkg::FUNC_SUB: return a ^ b;
      gfau_pkg::FUNC_INV: return field_power(a, gfau_pkg::InvExp, m);
      gfau_pkg::FUNC_POW: return field_power(a, b, m);
      default: return '0;
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  task automatic queue_op(logic [gfau_pkg::FuncW-1:0] f, logic [gfau_pkg::ByteW-1:0] a,
                          logic [gfau_pkg::ByteW-1:0] b, logic hold = 1'b0);
    op_t op;
    op.func           = f;
    op.operand_a      = a;
    op.operand_b      = b;
    op.hold_for_drain = hold;
    ops_pending.push_back(op);
  endtask

  // Operands lean toward 0, 1 and 0xFF, the rest uniform.
  function automatic logic [gfau_pkg::ByteW-1:0] pick_byte();
    case ($urandom_range(9))
      0: return '0;
      1: return gfau_pkg::ByteOne;
      2: return '1;
      default: return gfau_pkg::ByteW'($urandom_range(255));
    endcase
  endfunction

  // hold_at < 0: no drain pause in this batch
  task automatic queue_random(int count, int hold_at);
    logic [gfau_pkg::FuncW-1:0] f;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 4) begin
        f = $urandom_range(1) ? FuncSpare7 : FuncSpare6;
      end else begin
        f = gfau_pkg::FuncW'($urandom_range(int'(gfau_pkg::FUNC_POW)));
      end
      queue_op(f, pick_byte(), pick_byte(), n == hold_at);
    end
  endtask

  // Block until the driver is empty and every answer is back, then let the
  // sequencer fall back to idle before touching the register.
  task automatic wait_quiet();
    do @(posedge clk_i);
    while (ops_pending.size() != 0 || req_if.valid || answers_due.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_modulus(logic [gfau_pkg::PolyW-1:0] value);
    @(posedge clk_i);
    cfg_we        <= 1'b1;
    cfg_wdata     <= value;
    field_modulus  = value;  // nothing in flight, safe to switch now
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // Request driver: predicts on each accepted beat, then refills the slot.
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin : req_driver
    answer_t ans;
    op_t     op;
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        ans.func      = req_if.func;
        ans.operand_a = req_if.operand_a;
        ans.operand_b = req_if.operand_b;
        ans.modulus   = field_modulus;
        ans.result    = gf_answer(req_if.func, req_if.operand_a, req_if.operand_b,
                                  field_modulus);
        answers_due.push_back(ans);
      end
      if (!req_if.valid || req_if.ready) begin
        if (ops_pending.size() == 0 ||
            (ops_pending[0].hold_for_drain && answers_due.size() != 0) ||
            $urandom_range(99) < send_gap_pct) begin
          req_if.valid <= 1'b0;
        end else begin
          op = ops_pending.pop_front();
          req_if.valid     <= 1'b1;
          req_if.func      <= op.func;
          req_if.operand_a <= op.operand_a;
          req_if.operand_b <= op.operand_b;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result monitor: random backpressure, in-order compare.
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin : rsp_monitor
    answer_t want;
    rsp_if.ready <= rst_ni && ($urandom_range(99) >= recv_stall_pct);
    if (rsp_if.valid && rsp_if.ready) begin
      if (answers_due.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportLimit) begin
          $display("result beat %02h with nothing outstanding", rsp_if.result);
        end
      end else begin
        want = answers_due.pop_front();
        if (rsp_if.result !== want.result) begin
          mismatches++;
          if (mismatches <= ReportLimit) begin
            $display("func %0d a %02h b %02h poly %03h: expected %02h, got %02h",
                     want.func, want.operand_a, want.operand_b, want.modulus,
                     want.result, rsp_if.result);
          end
        end
      end
    end
  end

  // Hang guard: any beat on either channel restarts the count.
  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------
  initial begin
    req_if.valid     = 1'b0;
    req_if.func      = '0;
    req_if.operand_a = '0;
    req_if.operand_b = '0;
    rsp_if.ready     = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // light sender gaps, heavy result backpressure
    send_gap_pct   = 6;
    recv_stall_pct = 71;

    // Directed set at the reset modulus 0x11D.
    queue_op(gfau_pkg::FUNC_MUL, 8'h00, 8'h00);
    queue_op(gfau_pkg::FUNC_MUL, 8'hFF, 8'hFF);
    queue_op(gfau_pkg::FUNC_MUL, 8'h80, 8'h02);          // single reduction step
    queue_op(gfau_pkg::FUNC_MUL, 8'h01, 8'hA7);
    queue_op(gfau_pkg::FUNC_DIV, 8'h5C, 8'h00);          // divide by zero -> 0
    queue_op(gfau_pkg::FUNC_DIV, 8'hFF, 8'h01);
    queue_op(gfau_pkg::FUNC_DIV, 8'h57, 8'h83);
    queue_op(gfau_pkg::FUNC_DIV, 8'h00, 8'hFF);
    queue_op(gfau_pkg::FUNC_ADD, 8'hFF, 8'h00);
    queue_op(gfau_pkg::FUNC_ADD, 8'hA5, 8'h5A);
    queue_op(gfau_pkg::FUNC_SUB, 8'hFF, 8'hFF);
    queue_op(gfau_pkg::FUNC_SUB, 8'h12, 8'h34);
    queue_op(gfau_pkg::FUNC_INV, 8'h00, 8'hFF);          // inverse of zero -> 0
    queue_op(gfau_pkg::FUNC_INV, 8'h01, 8'h00);
    queue_op(gfau_pkg::FUNC_INV, 8'hFF, 8'h3C);
    queue_op(gfau_pkg::FUNC_INV, 8'h53, 8'hC3);
    queue_op(gfau_pkg::FUNC_POW, 8'h00, 8'h00);          // 0^0 = 1
    queue_op(gfau_pkg::FUNC_POW, 8'h07, 8'h00);
    queue_op(gfau_pkg::FUNC_POW, 8'h00, 8'h05);
    queue_op(gfau_pkg::FUNC_POW, 8'hFF, 8'hFF);          // longest exponent
    queue_op(gfau_pkg::FUNC_POW, 8'h02, 8'hFE);
    queue_op(gfau_pkg::FUNC_POW, 8'h03, 8'h01);
    queue_op(FuncSpare6, 8'hFF, 8'hFF);                  // unused codes answer 0
    queue_op(FuncSpare7, 8'hAA, 8'h55);
    wait_quiet();

    // AES modulus; one batch item waits for a full drain
    write_modulus(9'h11B);
    queue_random(300, 40);
    wait_quiet();

    // heavy sender gaps, light backpressure; extreme moduli (both reducible)
    send_gap_pct   = 71;
    recv_stall_pct = 6;
    write_modulus(9'h100);
    queue_random(150, -1);
    wait_quiet();
    write_modulus(9'h1FF);
    queue_random(150, -1);
    wait_quiet();

    // back to back, no idling on either side
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    write_modulus(gfau_pkg::PolyW'($urandom_range(511, 256)));
    queue_random(200, 100);
    wait_quiet();
    write_modulus(gfau_pkg::PolyReset);
    queue_random(275, -1);
    wait_quiet();

    if (mismatches == 0 && answers_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
